>>> sv/mses_pkg.sv
`timescale 1ns / 1ps

package mses_pkg;

	localparam int SCREEN_ROWS_DEF = 600;

	localparam int NUM_PARTIALS = 12;
	localparam int MAP_PARTIALS = 4;

	localparam logic [2:0] REG_REAL_ORIGIN = 3'd0;
	localparam logic [2:0] REG_IMAG_ORIGIN = 3'd1;
	localparam logic [2:0] REG_STEP_REAL   = 3'd2;
	localparam logic [2:0] REG_STEP_IMAG   = 3'd3;
	localparam logic [2:0] REG_ITER_LIMIT  = 3'd4;

	localparam logic [63:0] REAL_ORIGIN_RST = 64'hE000_0000_0000_0000;
	localparam logic [63:0] IMAG_ORIGIN_RST = 64'hEE00_0000_0000_0000;
	localparam logic [62:0] STEP_RST        = 63'd4323455642275676;
	localparam logic [7:0]  ITER_LIMIT_RST  = 8'd62;

	typedef logic [15:0] mlog_tab_t [256];

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_MAP    = 10'b0000000010,
		S_MAPFIN = 10'b0000000100,
		S_UPD    = 10'b0000001000,
		S_MUL    = 10'b0000010000,
		S_CHK    = 10'b0000100000,
		S_LOG1   = 10'b0001000000,
		S_LOG2   = 10'b0010000000,
		S_HUE    = 10'b0100000000,
		S_OUT    = 10'b1000000000
	} state_t;

	function automatic mlog_tab_t build_mlog();
		mlog_tab_t   tab;
		logic [63:0]  y;
		logic [127:0] s;
		logic [15:0]  r;
		for (int k = 0; k < 256; k++) begin
			y = 64'(256 + k) << 54;
			r = '0;
			for (int b = 15; b >= 0; b--) begin
				s = {64'b0, y} * {64'b0, y};
				y = s[125:62];
				if (y[63]) begin
					r[b] = 1'b1;
					y = y >> 1;
				end
			end
			tab[k] = r;
		end
		return tab;
	endfunction

	localparam mlog_tab_t MANT_LOG2 = build_mlog();

	function automatic logic [63:0] sat64(input logic signed [129:0] v);
		logic [63:0] r;
		if (v[129:63] == '0 || v[129:63] == '1)
			r = v[63:0];
		else if (v[129])
			r = 64'h8000_0000_0000_0000;
		else
			r = 64'h7FFF_FFFF_FFFF_FFFF;
		return r;
	endfunction

endpackage

>>> sv/mandelbrot_smooth_escape_pixel.sv
`timescale 1ns / 1ps
// A run ends when the point escapes in iteration n (1..255) or after the full limit of n iterations (0..255).
// Throughput: one pixel at a time; s_tready is high only while the sequencer is idle.
// Each iteration runs on the single shared 32x32 multiplier (12 partial products).
// The result register frees the sequencer as soon as the word is stored.
// Reset (arst_n low, asynchronous): sequencer idle, no result held, registers to defaults.
module mandelbrot_smooth_escape_pixel #(
	parameter int SCREEN_ROWS = mses_pkg::SCREEN_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // pixel_col[9:0], pixel_row[19:10]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // hue[12:0], inside_res[13]
);

	localparam int TW = $clog2(2 * SCREEN_ROWS + 2048) + 1;

	logic [63:0] real_origin_q, imag_origin_q;
	logic [62:0] step_real_q, step_imag_q;
	logic [7:0]  lim_q;

	mses_pkg::state_t state_q;
	logic [3:0]   cnt_q;
	logic [7:0]   it_q;
	logic [TW-1:0] tr_q, ti_q;
	logic         ti_neg_q;
	logic [63:0]  cr_q, ci_q, zr_q, zi_q;
	logic [127:0] acc_a_q, acc_b_q, acc_c_q, m_q;
	logic         csgn_q;
	logic [18:0]  l1_q;
	logic signed [25:0] nu_q;
	logic [12:0]  hue_q;
	logic         inside_q;

	logic [63:0]  prod_s1;
	logic         valid_s1;
	logic [1:0]   sh_s1, dst_s1;

	logic [15:0]  out_q;
	logic         out_valid_q;

	logic [63:0]  mag_r, mag_i, mx, my;
	logic [31:0]  op_a, op_b;
	logic [1:0]   sh_c, dst_c;
	logic         issue;

	logic signed [TW-1:0] t_row;
	logic [127:0] pb;
	logic signed [129:0] map_r, map_i, nr, ni, csig;
	logic [127:0] msum;
	logic         esc;
	logic [2:0]   e1;
	logic [7:0]   k1, k2;
	logic [1:0]   e2;
	logic [18:0]  l2;
	logic signed [29:0] n10, n10m;
	logic [13:0]  hmag;

	assign s_tready = (state_q == mses_pkg::S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	assign mag_r = zr_q[63] ? (64'd0 - zr_q) : zr_q;
	assign mag_i = zi_q[63] ? (64'd0 - zi_q) : zi_q;
	assign t_row = TW'(2 * SCREEN_ROWS - 1) - TW'({s_tdata[19:10], 1'b0});

	always_comb begin
		mx = '0; my = '0; op_a = '0; op_b = '0; sh_c = '0; dst_c = '0; issue = 1'b0;
		if (state_q == mses_pkg::S_MAP && cnt_q < 4'(mses_pkg::MAP_PARTIALS)) begin
			issue = 1'b1;
			dst_c = {1'b0, cnt_q[1]};
			sh_c  = {1'b0, cnt_q[0]};
			case (cnt_q[1:0])
				2'd0: op_a = step_real_q[31:0];
				2'd1: op_a = {1'b0, step_real_q[62:32]};
				2'd2: op_a = step_imag_q[31:0];
				default: op_a = {1'b0, step_imag_q[62:32]};
			endcase
			op_b = cnt_q[1] ? 32'(ti_q) : 32'(tr_q);
		end else if (state_q == mses_pkg::S_MUL && cnt_q < 4'(mses_pkg::NUM_PARTIALS)) begin
			issue = 1'b1;
			dst_c = cnt_q[3:2];
			case (cnt_q[3:2])
				2'd0: begin mx = mag_r; my = mag_r; end
				2'd1: begin mx = mag_i; my = mag_i; end
				default: begin mx = mag_r; my = mag_i; end
			endcase
			op_a = cnt_q[1] ? mx[63:32] : mx[31:0];
			op_b = cnt_q[0] ? my[63:32] : my[31:0];
			sh_c = 2'(cnt_q[1]) + 2'(cnt_q[0]);
		end
	end

	always_comb begin
		pb    = ti_neg_q ? (128'd0 - acc_b_q) : acc_b_q;
		map_r = ($signed({2'b0, acc_a_q}) + 130'($signed({real_origin_q, 1'b0}))) >>> 1;
		map_i = ($signed({{2{pb[127]}}, pb}) + 130'($signed({imag_origin_q, 1'b0}))) >>> 1;
		nr    = (($signed({2'b0, acc_a_q}) - $signed({2'b0, acc_b_q})) >>> 60)
		        + 130'($signed(cr_q));
		csig  = csgn_q ? -$signed({2'b0, acc_c_q}) : $signed({2'b0, acc_c_q});
		ni    = (csig >>> 59) + 130'($signed(ci_q));
		msum  = acc_a_q + acc_b_q;
		esc   = (msum[127:122] != '0) &&
		        !(msum[127:123] == '0 && msum[122] && msum[121:0] == '0);
	end

	always_comb begin
		if (m_q[127])      begin e1 = 3'd7; k1 = m_q[126:119]; end
		else if (m_q[126]) begin e1 = 3'd6; k1 = m_q[125:118]; end
		else if (m_q[125]) begin e1 = 3'd5; k1 = m_q[124:117]; end
		else if (m_q[124]) begin e1 = 3'd4; k1 = m_q[123:116]; end
		else if (m_q[123]) begin e1 = 3'd3; k1 = m_q[122:115]; end
		else               begin e1 = 3'd2; k1 = m_q[121:114]; end
		if (l1_q[18]) begin e2 = 2'd2; k2 = l1_q[17:10]; end
		else          begin e2 = 2'd1; k2 = l1_q[16:9];  end
		l2   = {1'b0, e2, 16'b0} + 19'(mses_pkg::MANT_LOG2[k2]);
		n10  = 30'(nu_q) * 30'sd10;
		n10m = -n10;
		hmag = n10[29] ? n10m[29:16] : n10[29:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_origin_q <= mses_pkg::REAL_ORIGIN_RST;
			imag_origin_q <= mses_pkg::IMAG_ORIGIN_RST;
			step_real_q   <= mses_pkg::STEP_RST;
			step_imag_q   <= mses_pkg::STEP_RST;
			lim_q         <= mses_pkg::ITER_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mses_pkg::REG_REAL_ORIGIN: real_origin_q <= cfg_data;
				mses_pkg::REG_IMAG_ORIGIN: imag_origin_q <= cfg_data;
				mses_pkg::REG_STEP_REAL:   step_real_q   <= cfg_data[62:0];
				mses_pkg::REG_STEP_IMAG:   step_imag_q   <= cfg_data[62:0];
				mses_pkg::REG_ITER_LIMIT:  lim_q         <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		sh_s1   <= sh_c;
		dst_s1  <= dst_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mses_pkg::S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == mses_pkg::S_OUT && (!out_valid_q || m_tready))
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				mses_pkg::S_IDLE: begin
					if (s_tvalid) begin
						cnt_q   <= '0;
						state_q <= mses_pkg::S_MAP;
					end
				end
				mses_pkg::S_MAP: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(mses_pkg::MAP_PARTIALS)) state_q <= mses_pkg::S_MAPFIN;
				end
				mses_pkg::S_MAPFIN: begin
					state_q <= (lim_q == '0) ? mses_pkg::S_OUT : mses_pkg::S_UPD;
				end
				mses_pkg::S_UPD: begin
					cnt_q   <= '0;
					state_q <= mses_pkg::S_MUL;
				end
				mses_pkg::S_MUL: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(mses_pkg::NUM_PARTIALS)) state_q <= mses_pkg::S_CHK;
				end
				mses_pkg::S_CHK: begin
					if (esc) state_q <= mses_pkg::S_LOG1;
					else if (9'(it_q) + 9'd1 == 9'(lim_q)) state_q <= mses_pkg::S_OUT;
					else state_q <= mses_pkg::S_UPD;
				end
				mses_pkg::S_LOG1: state_q <= mses_pkg::S_LOG2;
				mses_pkg::S_LOG2: state_q <= mses_pkg::S_HUE;
				mses_pkg::S_HUE:  state_q <= mses_pkg::S_OUT;
				mses_pkg::S_OUT: begin
					if (!out_valid_q || m_tready) state_q <= mses_pkg::S_IDLE;
				end
				default: state_q <= mses_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			case (dst_s1)
				2'd0: acc_a_q <= acc_a_q + ({64'b0, prod_s1} << {sh_s1, 5'b0});
				2'd1: acc_b_q <= acc_b_q + ({64'b0, prod_s1} << {sh_s1, 5'b0});
				default: acc_c_q <= acc_c_q + ({64'b0, prod_s1} << {sh_s1, 5'b0});
			endcase
		end
		case (state_q)
			mses_pkg::S_IDLE: begin
				tr_q     <= TW'({s_tdata[9:0], 1'b1});
				ti_q     <= t_row[TW-1] ? TW'(-t_row) : TW'(t_row);
				ti_neg_q <= t_row[TW-1];
				acc_a_q  <= '0;
				acc_b_q  <= '0;
				acc_c_q  <= '0;
			end
			mses_pkg::S_MAPFIN: begin
				cr_q     <= mses_pkg::sat64(map_r);
				ci_q     <= mses_pkg::sat64(map_i);
				acc_a_q  <= '0;
				acc_b_q  <= '0;
				acc_c_q  <= '0;
				it_q     <= '0;
				hue_q    <= '0;
				inside_q <= 1'b1;
			end
			mses_pkg::S_UPD: begin
				zr_q    <= mses_pkg::sat64(nr);
				zi_q    <= mses_pkg::sat64(ni);
				acc_a_q <= '0;
				acc_b_q <= '0;
				acc_c_q <= '0;
			end
			mses_pkg::S_MUL: begin
				csgn_q <= zr_q[63] ^ zi_q[63];
			end
			mses_pkg::S_CHK: begin
				m_q <= msum;
				if (!esc) it_q <= it_q + 8'd1;
			end
			mses_pkg::S_LOG1: begin
				l1_q <= {e1, 16'b0} + 19'(mses_pkg::MANT_LOG2[k1]);
			end
			mses_pkg::S_LOG2: begin
				nu_q <= $signed({1'b0, 9'(it_q) + 9'd1, 16'b0}) - $signed(26'(l2));
			end
			mses_pkg::S_HUE: begin
				if (nu_q > -26'sd65536) begin
					inside_q <= 1'b0;
					hue_q    <= n10[29] ? (13'd0 - hmag[12:0]) : hmag[12:0];
				end
			end
			mses_pkg::S_OUT: begin
				if (!out_valid_q || m_tready) out_q <= {2'b0, inside_q, hue_q};
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_idle_no_product: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mses_pkg::S_IDLE) |-> !valid_s1)
		else $error("product in flight while idle");
	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mses_pkg::S_MUL) |-> (cnt_q <= 4'(mses_pkg::NUM_PARTIALS)))
		else $error("partial count overrun");
	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mses_pkg::S_UPD) |-> (it_q < lim_q))
		else $error("iteration beyond limit");
	a_log_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mses_pkg::S_LOG1) |-> (m_q[127:122] != '0))
		else $error("escape magnitude out of range");
`endif

endmodule

>>> tb/mandelbrot_smooth_escape_pixel_tb.sv
`timescale 1ns / 1ps

module mandelbrot_smooth_escape_pixel_tb;

	localparam int CYCLE_LIMIT = 40_000_000;

	typedef struct {
		logic [12:0] hue;
		logic        inside_res;
	} shade_t;

	class escape_scoreboard;
		logic signed [63:0] re_edge, im_edge;
		logic [62:0]        re_pitch, im_pitch;
		logic [7:0]         max_iter;
		logic [15:0]        frac_log [256];
		shade_t             shades [$];
		int                 errors;
		int                 checked;

		function new();
			logic [63:0]  y;
			logic [127:0] s;
			logic [15:0]  r;
			for (int k = 0; k < 256; k++) begin
				y = 64'(256 + k) << 54;
				r = '0;
				for (int b = 15; b >= 0; b--) begin
					s = {64'b0, y} * {64'b0, y};
					y = s[125:62];
					if (y[63]) begin
						r[b] = 1'b1;
						y = y >> 1;
					end
				end
				frac_log[k] = r;
			end
			re_edge = mses_pkg::REAL_ORIGIN_RST;
			im_edge = mses_pkg::IMAG_ORIGIN_RST;
			re_pitch = mses_pkg::STEP_RST;
			im_pitch = mses_pkg::STEP_RST;
			max_iter = mses_pkg::ITER_LIMIT_RST;
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [63:0] v);
			case (idx)
				mses_pkg::REG_REAL_ORIGIN: re_edge = v;
				mses_pkg::REG_IMAG_ORIGIN: im_edge = v;
				mses_pkg::REG_STEP_REAL:   re_pitch = v[62:0];
				mses_pkg::REG_STEP_IMAG:   im_pitch = v[62:0];
				mses_pkg::REG_ITER_LIMIT:  max_iter = v[7:0];
				default: ;
			endcase
		endfunction

		function logic signed [63:0] clamp(logic signed [129:0] v);
			if (v > 130'sh7FFF_FFFF_FFFF_FFFF)
				return 64'h7FFF_FFFF_FFFF_FFFF;
			if (v < -130'sh8000_0000_0000_0000)
				return 64'h8000_0000_0000_0000;
			return v[63:0];
		endfunction

		function int top_bit(logic [127:0] v);
			int p;
			p = 0;
			for (int j = 0; j < 128; j++)
				if (v[j]) p = j;
			return p;
		endfunction

		function logic signed [63:0] map_axis(logic [62:0] pitch, logic signed [63:0] edge0,
			int t);
			logic signed [129:0] tw, ow, prod;
			tw = 130'(t);
			ow = 130'(edge0);
			prod = $signed({67'b0, pitch}) * tw;
			return clamp((prod + (ow <<< 1)) >>> 1);
		endfunction

		function shade_t smooth_escape(int col, int row);
			logic signed [63:0]  cr, ci, zr, zi;
			logic signed [129:0] zrw, ziw, crw, ciw;
			logic [63:0]         ar, ai;
			logic [127:0]        m;
			logic [31:0]         l1;
			int                  p, k, p2, k2;
			longint              l2, nu, n10;
			shade_t              res;
			cr = map_axis(re_pitch, re_edge, 2 * col + 1);
			ci = map_axis(im_pitch, im_edge, 2 * (mses_pkg::SCREEN_ROWS_DEF - row - 1) + 1);
			crw = 130'(cr);
			ciw = 130'(ci);
			zr = '0;
			zi = '0;
			res.hue = '0;
			res.inside_res = 1'b1;
			for (int i = 0; i < max_iter; i++) begin
				zrw = 130'(zr);
				ziw = 130'(zi);
				zr = clamp(((zrw * zrw - ziw * ziw) >>> 60) + crw);
				zi = clamp(((zrw * ziw) >>> 59) + ciw);
				ar = zr[63] ? -zr : zr;
				ai = zi[63] ? -zi : zi;
				m = {64'b0, ar} * {64'b0, ar} + {64'b0, ai} * {64'b0, ai};
				if (m > (128'd1 << 122)) begin
					p = top_bit(m);
					k = int'((m >> (p - 8)) & 128'hFF);
					l1 = ((p - 120) << 16) + frac_log[k];
					p2 = top_bit({96'b0, l1});
					k2 = (l1 >> (p2 - 8)) & 32'hFF;
					l2 = (longint'(p2 - 16) << 16) + frac_log[k2];
					nu = (longint'(i + 1) << 16) - l2;
					if (nu > -65536) begin
						n10 = nu * 10;
						res.hue = n10 >= 0 ? 13'(n10 >>> 16) : 13'(-((-n10) >>> 16));
						res.inside_res = 1'b0;
					end
					break;
				end
			end
			return res;
		endfunction

		function void note_pixel(logic [23:0] word);
			shades.push_back(smooth_escape(word[9:0], word[19:10]));
		endfunction

		function void check_word(logic [15:0] word);
			shade_t e;
			checked++;
			if (shades.size() == 0) begin
				$error("unexpected result word %h", word);
				errors++;
				return;
			end
			e = shades.pop_front();
			if (word[12:0] !== e.hue) begin
				$error("hue expected %0d actual %0d", $signed(e.hue), $signed(word[12:0]));
				errors++;
			end
			if (word[13] !== e.inside_res) begin
				$error("inside_res expected %0d actual %0d", e.inside_res, word[13]);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // pixel_col[9:0], pixel_row[19:10]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // hue[12:0], inside_res[13]

	escape_scoreboard sb;
	bit  calm;
	bit  held;
	int  hold_left;
	int  cycles;

	mandelbrot_smooth_escape_pixel dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("mandelbrot_smooth_escape_pixel verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_pixel(s_tdata);
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata);
	end

	// receiver: random stalls plus one long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!held && sb.checked >= 200) begin
				held = 1;
				hold_left = 400;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || $urandom_range(99) >= 7;
			end
		end
	end

	task automatic send_pixel(int col, int row);
		while (!calm && $urandom_range(99) < 7) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, 10'(row), 10'(col)};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.shades.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_view(logic [63:0] ro, logic [63:0] io, logic [62:0] sr,
		logic [62:0] si, logic [7:0] lim);
		logic [63:0] vals [5];
		logic [2:0]  idx [5];
		vals = '{ro, io, {1'b0, sr}, {1'b0, si}, {56'b0, lim}};
		idx = '{mses_pkg::REG_REAL_ORIGIN, mses_pkg::REG_IMAG_ORIGIN, mses_pkg::REG_STEP_REAL,
			mses_pkg::REG_STEP_IMAG, mses_pkg::REG_ITER_LIMIT};
		drain();
		for (int j = 0; j < 5; j++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[j];
			cfg_data <= vals[j];
			sb.set_reg(idx[j], vals[j]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_pixels(int n);
		for (int j = 0; j < n; j++)
			send_pixel($urandom_range(1023), $urandom_range(1023));
	endtask

	initial begin
		int          dcol [12];
		int          drow [12];
		logic [63:0] ro, io;
		logic [62:0] sr, si;
		logic [7:0]  lim;
		int          n;
		dcol = '{0, 799, 1023, 0, 1023, 400, 266, 533, 100, 799, 0, 512};
		drow = '{0, 599, 1023, 1023, 0, 300, 300, 300, 150, 0, 599, 700};
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		calm = 0;
		held = 0;
		hold_left = 0;
		cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int j = 0; j < 12; j++)
			send_pixel(dcol[j], drow[j]);
		set_view(mses_pkg::REAL_ORIGIN_RST, mses_pkg::IMAG_ORIGIN_RST, mses_pkg::STEP_RST,
			mses_pkg::STEP_RST, 8'd0);
		random_pixels(3);
		set_view(mses_pkg::REAL_ORIGIN_RST, mses_pkg::IMAG_ORIGIN_RST, mses_pkg::STEP_RST,
			mses_pkg::STEP_RST, 8'd1);
		random_pixels(3);
		set_view(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, '1, '0, 8'd255);
		random_pixels(4);
		set_view(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, '0, '1, 8'd255);
		random_pixels(4);
		set_view('0, '0, '0, '0, 8'd255);
		random_pixels(2);

		for (int ph = 0; ph < 12; ph++) begin
			calm = (ph == 3);
			n = 130;
			ro = mses_pkg::REAL_ORIGIN_RST + ($signed({$urandom, $urandom}) >>> 4);
			io = mses_pkg::IMAG_ORIGIN_RST + ($signed({$urandom, $urandom}) >>> 5);
			sr = 63'({$urandom, $urandom} % (2 * mses_pkg::STEP_RST));
			si = 63'({$urandom, $urandom} % (2 * mses_pkg::STEP_RST));
			lim = 8'($urandom_range(4, 80));
			if (ph == 5) begin
				lim = 8'd255;
				n = 40;
			end else if (ph == 9) begin
				ro = {$urandom, $urandom};
				io = {$urandom, $urandom};
				sr = 63'({$urandom, $urandom});
				si = 63'({$urandom, $urandom});
				lim = 8'($urandom_range(1, 255));
			end
			set_view(ro, io, sr, si, lim);
			random_pixels(n);
		end
		calm = 0;

		drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.shades.size() == 0)
			$display("mandelbrot_smooth_escape_pixel verification clean");
		else
			$display("mandelbrot_smooth_escape_pixel verification failed");
		$finish;
	end

endmodule

>>> sim.f
sv/mses_pkg.sv
sv/mandelbrot_smooth_escape_pixel.sv
tb/mandelbrot_smooth_escape_pixel_tb.sv
